/* rtl/smn_pkg.sv */
// ----------------------------------------------------------------------------
// smn_pkg
// Shared types, constants and the elaboration-time exp tables of the softmax
// vector normalizer.
// ----------------------------------------------------------------------------
package smn_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int SCORE_W          = 16;
    localparam int EXP_W            = 17;
    localparam int PROB_W           = 16;
    localparam int DIV_W            = 30;
    localparam int DIV_CNT_W        = 5;
    localparam int EXP_CUTOFF       = 3072;

    localparam longint unsigned DEC_ONE  = 64'd1000000000;
    localparam longint unsigned DEC_HALF = 64'd500000000;

    // floor(2^62 / 10^9), quotient estimate for the decimal rescale
    localparam logic [32:0] DEC_RECIP = 33'd4611686018;

    typedef longint unsigned t_factor_arr [0:11];

    // exp(-2^b/256) scaled by 10^9
    localparam t_factor_arr EXP_FACTOR = '{
        64'd996101369, 64'd992217938, 64'd984496437, 64'd969233234,
        64'd939413063, 64'd882496903, 64'd778800783, 64'd606530660,
        64'd367879441, 64'd135335283, 64'd18315639,  64'd335463
    };

    typedef logic [DIV_W-1:0] t_exp_lo_table [0:255];
    typedef logic [DIV_W-1:0] t_exp_hi_table [0:3];

    function automatic t_exp_lo_table f_exp_lo_table();
        t_exp_lo_table    t;
        longint unsigned  p;
        for (int i = 0; i < 256; i++) begin
            p = DEC_ONE;
            for (int b = 0; b < 8; b++) begin
                if (((i >> b) & 1) != 0) begin
                    p = (p * EXP_FACTOR[b] + DEC_HALF) / DEC_ONE;
                end
            end
            t[i] = p[DIV_W-1:0];
        end
        return t;
    endfunction

    // product over the low eight bits of the distance from the maximum
    localparam t_exp_lo_table EXP_LO_TABLE = f_exp_lo_table();

    localparam t_exp_hi_table EXP_HI_TABLE = '{
        EXP_FACTOR[8][DIV_W-1:0],  EXP_FACTOR[9][DIV_W-1:0],
        EXP_FACTOR[10][DIV_W-1:0], EXP_FACTOR[11][DIV_W-1:0]
    };

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     rem0;
        logic [DIV_W-1:0]     low;
        logic [DIV_CNT_W-1:0] count;
        logic [DIV_W-1:0]     divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

endpackage

/* rtl/smn_if.sv */
// ----------------------------------------------------------------------------
// smn_in_if / smn_out_if
// Valid/ready channels for scores in and probabilities out.
// ----------------------------------------------------------------------------
interface smn_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] score;
    logic               final_element;

    modport source(output valid, score, final_element, input ready);
    modport sink(input valid, score, final_element, output ready);
endinterface

interface smn_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] probability;
    logic        final_result;

    modport source(output valid, probability, final_result, input ready);
    modport sink(input valid, probability, final_result, output ready);
endinterface

/* rtl/smn_ram.sv */
// ----------------------------------------------------------------------------
// smn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/smn_div.sv */
// ----------------------------------------------------------------------------
// smn_div
// Restoring divider, one quotient bit per cycle, used for the probability
// normalization.
// ----------------------------------------------------------------------------
module smn_div
    import smn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_low;
    logic [DIV_W-1:0]     r_quot;
    logic [DIV_W-1:0]     r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W:0]       trial;

    assign trial = {r_rem, r_low[DIV_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rem  <= i_req.rem0;
                r_low  <= i_req.low;
                r_quot <= '0;
                r_div  <= i_req.divisor;
                r_cnt  <= i_req.count;
            end else if (r_busy) begin
                if (trial >= {1'b0, r_div}) begin
                    r_rem  <= DIV_W'(trial - {1'b0, r_div});
                    r_quot <= {r_quot[DIV_W-2:0], 1'b1};
                end else begin
                    r_rem  <= trial[DIV_W-1:0];
                    r_quot <= {r_quot[DIV_W-2:0], 1'b0};
                end
                r_low <= {r_low[DIV_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

/* rtl/softmax_vector_normalizer.sv */
// ----------------------------------------------------------------------------
// softmax_vector_normalizer
// Numerically stable softmax over a vector of signed Q8.8 scores.
// ----------------------------------------------------------------------------
// Scores are taken one per cycle into a score RAM while the maximum is
// tracked; the score flagged final ends the vector (scores past
// MAX_ELEMENTS are dropped). The block then runs two passes over the stored
// elements and takes no scores until the last probability is transferred.
// In the exp pass the low eight bits of each element's distance from the
// maximum select a table factor, and one rescaled product follows for each
// of distance bits 8 to 11 that is set; an element past the exp cutoff gets
// zero. The output pass divides each exp by the sum in the one-bit-per-cycle
// divider and waits for each probability to be taken.
// ----------------------------------------------------------------------------
module softmax_vector_normalizer
    import smn_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smn_in_if.sink      i_in,
    smn_out_if.source   o_out
);

    localparam int AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int SUM_W = $clog2(MAX_ELEMENTS) + EXP_W;

    typedef enum logic [3:0] {
        S_LOAD, S_E_RD, S_E_A, S_E_MUL, S_E_ADD, S_E_EST, S_E_BACK, S_E_FIX,
        S_E_WR, S_O_RD, S_O_ST, S_O_DIV, S_O_HOLD
    } t_state;

    t_state                r_state;
    logic signed [15:0]    r_max;
    logic [SUM_W-1:0]      r_sum;
    logic [CNT_W-1:0]      r_count;
    logic [AW-1:0]         r_idx;
    logic [DIV_W-1:0]      r_p;
    logic [3:0]            r_bits;
    logic [2*DIV_W-1:0]    r_prod;
    logic                  r_fin;
    logic [2*DIV_W-1:0]    r_x;
    logic [DIV_W-1:0]      r_q;
    logic [31:0]           r_back;
    logic [EXP_W-1:0]      r_e;
    logic                  r_out_valid;
    logic [PROB_W-1:0]     r_prob;
    logic                  r_final;

    logic                  in_xfer;
    logic                  store_en;
    logic [SCORE_W-1:0]    score_rd;
    logic [EXP_W-1:0]      exp_rd;
    logic [16:0]           span;
    logic [1:0]            bit_sel;
    logic                  last_idx;
    logic [DIV_W+32:0]     est_prod;
    logic [31:0]           back_lo;
    logic [31:0]           fix_rem;
    logic [DIV_W-1:0]      fix_q;
    t_div_req              div_req;
    t_div_rsp              div_rsp;

    assign in_xfer  = (r_state == S_LOAD) && i_in.valid;
    assign store_en = in_xfer && (r_count < CNT_W'(MAX_ELEMENTS));
    assign last_idx = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;
    assign span     = {r_max[15], r_max} - {score_rd[15], score_rd};
    assign est_prod = r_x[2*DIV_W-1:DIV_W] * DEC_RECIP;
    assign back_lo  = 32'(r_q) * 32'(DEC_ONE);
    assign fix_rem  = r_x[31:0] - r_back;
    assign fix_q    = r_q + DIV_W'(fix_rem >= 32'(DEC_ONE))
                          + DIV_W'(fix_rem >= 32'(2 * DEC_ONE));

    always_comb begin
        if (r_bits[0]) begin
            bit_sel = 2'd0;
        end else if (r_bits[1]) begin
            bit_sel = 2'd1;
        end else if (r_bits[2]) begin
            bit_sel = 2'd2;
        end else begin
            bit_sel = 2'd3;
        end
    end

    always_comb begin
        div_req = '0;
        case (r_state)
            S_O_ST: begin
                div_req.start   = 1'b1;
                div_req.rem0    = DIV_W'(exp_rd[EXP_W-1:1]);
                div_req.low     = {exp_rd[0], {(DIV_W-1){1'b0}}};
                div_req.count   = DIV_CNT_W'(17);
                div_req.divisor = DIV_W'(r_sum);
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    smn_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_ELEMENTS)) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (store_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in.score),
        .i_re    (r_state == S_E_RD),
        .i_raddr (r_idx),
        .o_rdata (score_rd)
    );

    smn_ram #(.WIDTH(EXP_W), .DEPTH(MAX_ELEMENTS)) u_exp_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_E_WR),
        .i_waddr (r_idx),
        .i_wdata (r_e),
        .i_re    (r_state == S_O_RD),
        .i_raddr (r_idx),
        .o_rdata (exp_rd)
    );

    smn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_max       <= 16'sh8000;
            r_sum       <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (store_en) begin
                        r_count <= r_count + 1'b1;
                        if (i_in.score > r_max) begin
                            r_max <= i_in.score;
                        end
                    end
                    if (in_xfer && i_in.final_element) begin
                        r_idx   <= '0;
                        r_sum   <= '0;
                        r_state <= S_E_RD;
                    end
                end
                S_E_RD: begin
                    r_state <= S_E_A;
                end
                S_E_A: begin
                    if (span > 17'(EXP_CUTOFF)) begin
                        r_e     <= '0;
                        r_state <= S_E_WR;
                    end else begin
                        r_p     <= EXP_LO_TABLE[span[7:0]];
                        r_bits  <= span[11:8];
                        r_state <= S_E_MUL;
                    end
                end
                S_E_MUL: begin
                    if (r_bits == 4'd0) begin
                        r_prod <= (2*DIV_W)'({r_p, 16'b0});
                        r_fin  <= 1'b1;
                    end else begin
                        r_prod          <= r_p * EXP_HI_TABLE[bit_sel];
                        r_bits[bit_sel] <= 1'b0;
                        r_fin           <= 1'b0;
                    end
                    r_state <= S_E_ADD;
                end
                S_E_ADD: begin
                    r_x     <= r_prod + (2*DIV_W)'(DEC_HALF);
                    r_state <= S_E_EST;
                end
                S_E_EST: begin
                    r_q     <= est_prod[DIV_W+31:32];
                    r_state <= S_E_BACK;
                end
                S_E_BACK: begin
                    r_back  <= back_lo;
                    r_state <= S_E_FIX;
                end
                S_E_FIX: begin
                    if (r_fin) begin
                        r_e     <= fix_q[EXP_W-1:0];
                        r_state <= S_E_WR;
                    end else begin
                        r_p     <= fix_q;
                        r_state <= S_E_MUL;
                    end
                end
                S_E_WR: begin
                    r_sum <= r_sum + SUM_W'(r_e);
                    if (last_idx) begin
                        r_idx   <= '0;
                        r_state <= S_O_RD;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_E_RD;
                    end
                end
                S_O_RD: begin
                    r_state <= S_O_ST;
                end
                S_O_ST: begin
                    r_state <= S_O_DIV;
                end
                S_O_DIV: begin
                    if (div_rsp.done) begin
                        r_prob      <= div_rsp.quot[16] ? '1 : div_rsp.quot[15:0];
                        r_final     <= last_idx;
                        r_out_valid <= 1'b1;
                        r_state     <= S_O_HOLD;
                    end
                end
                S_O_HOLD: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        if (r_final) begin
                            r_max   <= 16'sh8000;
                            r_sum   <= '0;
                            r_count <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_O_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_LOAD);
    assign o_out.valid       = r_out_valid;
    assign o_out.probability = r_prob;
    assign o_out.final_result = r_final;

endmodule

/* tb/softmax_vector_normalizer_tb.sv */
// ----------------------------------------------------------------------------
// softmax_vector_normalizer_tb
// Self-checking bench: sends scores over the input channel, predicts every
// probability of each vector with a bit-accurate fixed-point softmax model
// and compares results in order under random gaps and output stalls.
// ----------------------------------------------------------------------------
module softmax_vector_normalizer_tb;
    import smn_pkg::*;

    localparam int VEC_MAX    = 64;
    localparam int CYCLE_CAP  = 1500000;

    typedef struct packed {
        logic [15:0] probability;
        logic        final_result;
    } t_prob;

    logic i_clk;
    logic i_rst_n;
    smn_in_if  in_ch();
    smn_out_if out_ch();

    softmax_vector_normalizer dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    logic signed [15:0] vec_scores [VEC_MAX];
    int                 vec_len;
    t_prob              prob_queue [$];
    int                 err_count;
    int                 cycle_count;
    bit                 stall_free;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [16:0] exp_of_distance(logic [16:0] span);
        longint unsigned p;
        p = DEC_ONE;
        if (span > 17'd3072) return '0;
        for (int b = 0; b < 12; b++) begin
            if (span[b]) p = (p * EXP_FACTOR[b] + DEC_HALF) / DEC_ONE;
        end
        return 17'((p * 65536 + DEC_HALF) / DEC_ONE);
    endfunction

    task automatic predict_vector();
        logic signed [15:0] peak;
        logic [16:0]        exps [VEC_MAX];
        longint unsigned    total;
        longint unsigned    q;
        t_prob              r;
        peak  = -16'sd32768;
        total = 0;
        for (int i = 0; i < vec_len; i++)
            if (vec_scores[i] > peak) peak = vec_scores[i];
        for (int i = 0; i < vec_len; i++) begin
            exps[i] = exp_of_distance(17'(int'(peak) - int'(vec_scores[i])));
            total += exps[i];
        end
        for (int i = 0; i < vec_len; i++) begin
            q = (total == 0) ? 0 : ((64'(exps[i]) << 16) / total);
            if (q > 65535) q = 65535;
            r.probability  = q[15:0];
            r.final_result = (i == vec_len - 1);
            prob_queue.push_back(r);
        end
        vec_len = 0;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        err_count++;
    endtask

    task automatic send_score(logic signed [15:0] s, logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.score         <= s;
        in_ch.final_element <= fin;
        do @(posedge i_clk); while (!in_ch.ready);
        if (vec_len < VEC_MAX) begin
            vec_scores[vec_len] = s;
            vec_len++;
        end
        if (fin) predict_vector();
    endtask

    task automatic send_vector(int n, int lo, int hi);
        for (int i = 0; i < n; i++)
            send_score(16'($urandom_range(0, hi - lo) + lo), i == n - 1);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (prob_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic test_single_element();
        send_score(16'sd32767, 1'b1);
        send_score(-16'sd32768, 1'b1);
        send_score(16'sd0, 1'b1);
    endtask

    task automatic test_extremes();
        send_score(16'sh7FFF, 1'b0);
        send_score(16'sh8000, 1'b0);
        send_score(16'sh5555, 1'b0);
        send_score(16'shAAAA, 1'b1);
        send_score(16'sd256, 1'b0);
        send_score(16'sd256, 1'b1);
        // distances at and around the exp cutoff
        send_score(16'sd3072, 1'b0);
        send_score(16'sd0, 1'b0);
        send_score(-16'sd1, 1'b0);
        send_score(16'sd3071, 1'b0);
        send_score(16'sd2049, 1'b1);
        drain();
    endtask

    task automatic test_overflow();
        for (int i = 0; i < VEC_MAX + 3; i++)
            send_score(16'($urandom_range(0, 4095)) - 16'sd2048, i == VEC_MAX + 2);
        drain();
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 12) begin
            int n;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 16)
                                             : $urandom_range(1, 8);
            case ($urandom_range(0, 2))
                0: send_vector(n, -32768, 32767);
                1: send_vector(n, -3200, 3200);
                default: send_vector(n, -512, 512);
            endcase
            sent += n;
            if ($urandom_range(0, 5) == 0) drain();
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_prob want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (prob_queue.size() == 0) begin
                report_mismatch("unexpected transfer", out_ch.probability, -1);
            end else begin
                want = prob_queue.pop_front();
                if (out_ch.probability !== want.probability)
                    report_mismatch("probability", out_ch.probability, want.probability);
                if (out_ch.final_result !== want.final_result)
                    report_mismatch("final_result", out_ch.final_result,
                                    want.final_result);
            end
        end
    end

    always @(posedge i_clk) begin
        int hold;
        if (!i_rst_n || stall_free) begin
            out_ch.ready <= 1'b1;
        end else if (hold > 0) begin
            hold--;
        end else if (out_ch.ready && $urandom_range(0, 3) == 0) begin
            out_ch.ready <= 1'b0;
            hold = pick_gap();
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.score         = '0;
        in_ch.final_element = 1'b0;
        out_ch.ready        = 1'b0;
        err_count           = 0;
        cycle_count         = 0;
        vec_len             = 0;
        stall_free          = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_element();
        test_extremes();
        test_overflow();
        test_random();
        stall_free = 1'b1;
        send_vector(12, -700, 700);
        drain();
        stall_free = 1'b0;
        repeat (200) @(posedge i_clk);
        if (err_count == 0 && prob_queue.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
